>>> hw/rtl/hcbp_pkg.sv
`timescale 1ns / 1ps

package hcbp_pkg;

    // Table geometry
    localparam int NUM_SYMBOLS  = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int SYM_W        = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int SYMIN_W = 8;
    localparam int LEN_W   = 6;
    localparam int CODE_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int VB_W    = 4;
    localparam int CNT_W   = 32;

    // Packer widths: a pending byte plus one longest code
    localparam int ACC_W   = BYTE_W + CODE_W;
    localparam int TOT_W   = 6;
    localparam int ENTRY_W = LEN_W + CODE_W;

    localparam int BYTE_BITS = 8;

    // Stored code length saturates here
    localparam logic [LEN_W-1:0] LEN_CAP =
        LEN_W'((MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_code_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic lookup;
        logic merge;
        logic emit;
        logic flush;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic code_empty;
        logic have_byte;
        logic last_byte;
    } dp_stat_t;

endpackage

>>> hw/rtl/hcbp_ram.sv
`timescale 1ns / 1ps

module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/hcbp_ctrl.sv
`timescale 1ns / 1ps

module hcbp_ctrl
    import hcbp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CMD_W-1:0] command,
    input  dp_stat_t         dp_stat,
    output dp_cmd_t          dp_cmd,
    output logic             busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode commands and sequence one encode
    always_comb
    begin
        dp_cmd     = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (command)
                        CMD_LOAD:   dp_cmd.load = 1'b1;
                        CMD_ENCODE:
                        begin
                            dp_cmd.lookup = 1'b1;
                            state_next    = ST_LOOKUP;
                        end
                        CMD_FLUSH:  dp_cmd.flush = 1'b1;
                        default:    dp_cmd = '0;
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                if (dp_stat.code_empty)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    dp_cmd.merge = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (dp_stat.have_byte)
                begin
                    dp_cmd.emit = 1'b1;
                    if (dp_stat.last_byte)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

>>> hw/rtl/hcbp_dpath.sv
`timescale 1ns / 1ps

module hcbp_dpath
    import hcbp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            dp_cmd,
    output dp_stat_t           dp_stat,
    input  logic [SYMIN_W-1:0] symbol,
    input  logic [LEN_W-1:0]   code_length,
    input  logic [CODE_W-1:0]  code_bits,
    output logic               result_strobe,
    output logic [BYTE_W-1:0]  out_byte,
    output logic [VB_W-1:0]    valid_bits,
    output logic               is_trailer,
    output logic [CNT_W-1:0]   full_byte_count,
    output logic               is_last
);

    logic [NUM_SYMBOLS-1:0] valid_reg;
    logic                   sym_ok;
    logic                   sym_ok_reg;
    logic                   entry_ok_reg;
    logic [SYM_W-1:0]       addr;
    logic [LEN_W-1:0]       len_sat;
    logic [CODE_W-1:0]      bits_mask;
    logic [ENTRY_W-1:0]     wr_entry;
    logic [ENTRY_W-1:0]     rd_entry;
    logic [LEN_W-1:0]       rd_len;
    logic [CODE_W-1:0]      rd_bits;

    logic [ACC_W-1:0]       acc_reg;
    logic [TOT_W-1:0]       total_reg;
    logic [CNT_W-1:0]       byte_cnt_reg;
    logic [ACC_W-1:0]       merged;
    logic [TOT_W-1:0]       merged_total;
    logic [CNT_W-1:0]       cnt_inc;

    logic                   strobe_reg;
    logic [BYTE_W-1:0]      byte_reg;
    logic [VB_W-1:0]        vbits_reg;
    logic                   trailer_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   last_reg;

    assign sym_ok = ({1'b0, symbol} < (SYMIN_W + 1)'(NUM_SYMBOLS));
    assign addr   = symbol[SYM_W-1:0];

    // Saturate the length and drop code bits above it
    assign len_sat   = (code_length > LEN_CAP) ? LEN_CAP : code_length;
    assign bits_mask = (len_sat >= LEN_W'(CODE_W)) ? {CODE_W{1'b1}}
                                                   : ~({CODE_W{1'b1}} << len_sat);
    assign wr_entry  = {len_sat, code_bits & bits_mask};

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_code_ram (
        .clk   (clk),
        .we    (dp_cmd.load && sym_ok),
        .waddr (addr),
        .wdata (wr_entry),
        .re    (dp_cmd.lookup),
        .raddr (addr),
        .rdata (rd_entry)
    );

    assign rd_len  = rd_entry[ENTRY_W-1:CODE_W];
    assign rd_bits = rd_entry[CODE_W-1:0];

    // Mark written entries; an unwritten entry reads as length zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            sym_ok_reg   <= 1'b0;
            entry_ok_reg <= 1'b0;
        end
        else
        begin
            if (dp_cmd.load && sym_ok)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (dp_cmd.lookup)
            begin
                sym_ok_reg   <= sym_ok;
                entry_ok_reg <= sym_ok && valid_reg[addr];
            end
        end
    end

    // Append the code above the pending bits
    assign merged       = {{CODE_W{1'b0}}, acc_reg[BYTE_W-1:0]}
                        | ({{BYTE_W{1'b0}}, rd_bits} << total_reg[2:0]);
    assign merged_total = {3'b000, total_reg[2:0]} + rd_len;
    assign cnt_inc      = (byte_cnt_reg == {CNT_W{1'b1}}) ? byte_cnt_reg
                                                          : byte_cnt_reg + CNT_W'(1);

    assign dp_stat.code_empty = !(sym_ok_reg && entry_ok_reg) || (rd_len == '0);
    assign dp_stat.have_byte  = (total_reg >= TOT_W'(BYTE_BITS));
    assign dp_stat.last_byte  = (total_reg < TOT_W'(2 * BYTE_BITS));

    // Packer state: accumulator, bit total and byte counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            total_reg    <= '0;
            byte_cnt_reg <= '0;
        end
        else if (dp_cmd.flush)
        begin
            acc_reg      <= '0;
            total_reg    <= '0;
            byte_cnt_reg <= '0;
        end
        else if (dp_cmd.merge)
        begin
            acc_reg   <= merged;
            total_reg <= merged_total;
        end
        else if (dp_cmd.emit)
        begin
            acc_reg      <= acc_reg >> BYTE_BITS;
            total_reg    <= total_reg - TOT_W'(BYTE_BITS);
            byte_cnt_reg <= cnt_inc;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= dp_cmd.emit || dp_cmd.flush;
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (dp_cmd.flush)
        begin
            byte_reg    <= acc_reg[BYTE_W-1:0];
            vbits_reg   <= {1'b0, total_reg[2:0]};
            trailer_reg <= (total_reg[2:0] != 3'd0);
            count_reg   <= byte_cnt_reg;
            last_reg    <= 1'b1;
        end
        else if (dp_cmd.emit)
        begin
            byte_reg    <= acc_reg[BYTE_W-1:0];
            vbits_reg   <= VB_W'(BYTE_BITS);
            trailer_reg <= 1'b0;
            count_reg   <= cnt_inc;
            last_reg    <= dp_stat.last_byte;
        end
    end

    assign result_strobe   = strobe_reg;
    assign out_byte        = byte_reg;
    assign valid_bits      = vbits_reg;
    assign is_trailer      = trailer_reg;
    assign full_byte_count = count_reg;
    assign is_last         = last_reg;

endmodule

>>> hw/rtl/huffman_code_bit_packer.sv
`timescale 1ns / 1ps

// Prefix-code bit packer. A command is taken when start is high and busy is
// low. A load writes one table entry. A flush puts its report on the result
// ports in the next cycle. An encode that packs n bytes (1 to 4) reads the
// code table RAM in the cycle in which it is taken, merges the code into the
// pending bits in the next, then shifts out the packed bytes, since the packer
// shifts out one byte per clock. An encode that completes no byte ends after
// the merge, and one whose code length is zero ends after the read. Each byte
// word is registered and appears in the cycle after the one that shifts it
// out. Each result word is shown for exactly one cycle with result_strobe
// high and must be taken then; the receiver cannot hold it off.
// is_last marks the final word of one command. The table needs no clearing pass
// after reset.
module huffman_code_bit_packer
    import hcbp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   command,
    input  logic [SYMIN_W-1:0] symbol,
    input  logic [LEN_W-1:0]   code_length,
    input  logic [CODE_W-1:0]  code_bits,
    output logic               result_strobe,
    output logic [BYTE_W-1:0]  out_byte,
    output logic [VB_W-1:0]    valid_bits,
    output logic               is_trailer,
    output logic [CNT_W-1:0]   full_byte_count,
    output logic               is_last
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    hcbp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .dp_stat (dp_stat),
        .dp_cmd  (dp_cmd),
        .busy    (busy)
    );

    hcbp_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .dp_cmd          (dp_cmd),
        .dp_stat         (dp_stat),
        .symbol          (symbol),
        .code_length     (code_length),
        .code_bits       (code_bits),
        .result_strobe   (result_strobe),
        .out_byte        (out_byte),
        .valid_bits      (valid_bits),
        .is_trailer      (is_trailer),
        .full_byte_count (full_byte_count),
        .is_last         (is_last)
    );

endmodule

>>> hw/rtl/hcbp_checker.sv
`timescale 1ns / 1ps

module hcbp_checker
    import hcbp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [CMD_W-1:0]   command,
    input logic               result_strobe,
    input logic [VB_W-1:0]    valid_bits,
    input logic               is_trailer,
    input logic [CNT_W-1:0]   full_byte_count,
    input logic               is_last
);

    // Bytes of one encode leave back to back
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !is_last |=> result_strobe)
        else $error("encode burst broken before its last word");

    // Flush answers in the next cycle with a last word
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == CMD_FLUSH) |=> result_strobe && is_last)
        else $error("flush report missing");

    // A trailer holds one to seven bits
    a_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && is_trailer |-> (valid_bits != 4'd0) && (valid_bits < 4'd8))
        else $error("trailer bit count out of range");

    // A full byte is always counted
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (valid_bits == 4'd8) |-> (full_byte_count != '0) && !is_trailer)
        else $error("full byte with zero count");

    // An encode keeps the block busy while its code is read
    a_encode: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == CMD_ENCODE) |=> busy)
        else $error("encode not held busy");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);
